// ===== hdl/htl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htl_pkg: shared types, constants and curve tables
// Holds the controller state and command encodings and the calibration ROM.
// ----------------------------------------------------------------------------
package htl_pkg;

  localparam int CURVES = 9;
  localparam int POINTS = 15;

  localparam logic [6:0] HUM_OPEN   = 7'd19;
  localparam logic [6:0] HUM_LOW    = 7'd20;
  localparam logic [6:0] HUM_HIGH   = 7'd90;
  localparam logic [6:0] HUM_SHORT  = 7'd91;
  localparam logic [6:0] HUM_OFFSET = 7'd15;

  localparam logic [15:0] OPEN_LIMIT_RST  = 16'd32;
  localparam logic [15:0] CLOSE_LIMIT_RST = 16'd65300;

  localparam logic [0:0] REG_OPEN  = 1'b0;
  localparam logic [0:0] REG_CLOSE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LIMIT, ST_MARGIN, ST_SEARCH, ST_DIV, ST_STORE, ST_BLEND, ST_DONE
  } state_t;

  typedef struct packed {
    logic   accept;
    state_t op;
  } cmd_t;

  typedef struct packed {
    logic result_item;
    logic limit_hit;
    logic margin_hit;
    logic found;
    logic div_done;
    logic pass_b;
    logic out_free;
  } status_t;

  localparam logic [15:0] CURVE_TAB [CURVES*POINTS] = '{
    16'd45, 16'd192, 16'd621, 16'd1505, 16'd3536, 16'd6891, 16'd11601, 16'd16471,
    16'd25825, 16'd33480, 16'd40987, 16'd46669, 16'd52126, 16'd56003, 16'd58838,
    16'd85, 16'd340, 16'd986, 16'd2129, 16'd5021, 16'd9140, 16'd15525, 16'd23334,
    16'd31774, 16'd40002, 16'd46458, 16'd51336, 16'd55790, 16'd58669, 16'd60752,
    16'd159, 16'd610, 16'd1577, 16'd3637, 16'd7294, 16'd12996, 16'd21082, 16'd29335,
    16'd38277, 16'd45972, 16'd51030, 16'd55200, 16'd58447, 16'd60395, 16'd61975,
    16'd284, 16'd1011, 16'd2617, 16'd5631, 16'd10732, 16'd16471, 16'd26784, 16'd35404,
    16'd44191, 16'd48891, 16'd54420, 16'd57681, 16'd60007, 16'd61603, 16'd62758,
    16'd517, 16'd1668, 16'd4157, 16'd8876, 16'd15643, 16'd24253, 16'd33191, 16'd41624,
    16'd48891, 16'd54038, 16'd57040, 16'd59348, 16'd61260, 16'd62351, 16'd63273,
    16'd881, 16'd2942, 16'd6596, 16'd12470, 16'd21752, 16'd31113, 16'd39489, 16'd46669,
    16'd52833, 16'd56516, 16'd59007, 16'd60752, 16'd62100, 16'd62989, 16'd63613,
    16'd1467, 16'd4419, 16'd9778, 16'd17402, 16'd28626, 16'd37563, 16'd45177, 16'd50494,
    16'd55952, 16'd58669, 16'd60597, 16'd61726, 16'd62758, 16'd63377, 16'd63903,
    16'd2403, 16'd6891, 16'd14065, 16'd24253, 16'd34686, 16'd42780, 16'd49704, 16'd55003,
    16'd57996, 16'd60159, 16'd61603, 16'd62478, 16'd63234, 16'd63639, 16'd64103,
    16'd3914, 16'd10033, 16'd19013, 16'd29335, 16'd39898, 16'd47387, 16'd53097, 16'd57040,
    16'd59508, 16'd61235, 16'd62313, 16'd62989, 16'd63561, 16'd63903, 16'd64263
  };

  localparam logic [8:0] LOW_MARGIN [CURVES] = '{
    9'd10, 9'd20, 9'd30, 9'd40, 9'd50, 9'd80, 9'd100, 9'd200, 9'd300
  };
  localparam logic [8:0] HIGH_MARGIN [CURVES] = '{
    9'd200, 9'd200, 9'd150, 9'd100, 9'd80, 9'd50, 9'd30, 9'd20, 9'd10
  };

  function automatic logic [15:0] curve_point(input logic [3:0] c, input logic [3:0] i);
    logic [7:0] addr;
    addr = 8'({4'd0, c} * 8'd15) + {4'd0, i};
    return CURVE_TAB[addr];
  endfunction

endpackage

// ===== hdl/htl_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htl_ctrl: sequencing controller
// Steps the datapath through limit check, curve evaluation and blending.
// ----------------------------------------------------------------------------
module htl_ctrl import htl_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_stall   = (state_r != ST_IDLE);
    cmd.accept = in_valid && (state_r == ST_IDLE);
    cmd.op     = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.accept && status.result_item) state_nxt = ST_LIMIT;
      end
      ST_LIMIT:  state_nxt = status.limit_hit ? ST_DONE : ST_MARGIN;
      ST_MARGIN: state_nxt = status.margin_hit ? ST_STORE : ST_SEARCH;
      ST_SEARCH: begin
        if (status.found) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (status.div_done) state_nxt = ST_STORE;
      end
      ST_STORE:  state_nxt = status.pass_b ? ST_BLEND : ST_MARGIN;
      ST_BLEND:  state_nxt = ST_DONE;
      ST_DONE: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== hdl/htl_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htl_dp: accumulator and linearization datapath
// Sums samples, searches the curve ROM, divides serially and blends curves.
// ----------------------------------------------------------------------------
module htl_dp import htl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output status_t     status,
  input  logic [11:0] in_adc_sample,
  input  logic signed [7:0] in_air_temperature,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  out_humidity_percent,
  output logic [15:0] out_sample_sum
);

  logic [15:0] acc_r, open_r, close_r, v_r, d_r;
  logic [4:0]  cnt_r;
  logic        first_r, pass_r, out_valid_r;
  logic [3:0]  ca_r, cb_r, idx_r;
  logic [2:0]  frac_r, q_r;
  logic [18:0] num_r;
  logic [6:0]  base_r, hcur_r, h1_r, hres_r, hum_r;
  logic [15:0] sum_out_r;

  logic [15:0] sum_add, sum_now;
  logic [4:0]  cnt_inc;
  logic [3:0]  cur_c, idx_prev;
  logic [15:0] lo, hi, ti, tp, d_now;
  logic [16:0] lo_sum, hi_sum;
  logic        m_open, m_low, m_short, m_high;
  logic [6:0]  margin_val;
  logic [18:0] num_init;
  logic signed [7:0] tm_full;
  logic [5:0]  tm;
  logic [12:0] tm_scaled;
  logic [3:0]  c_sel;
  logic signed [7:0]  diff;
  logic signed [10:0] prod;
  logic [9:0]  prod_abs;
  logic [19:0] q_scaled;
  logic [6:0]  q5, blend;
  logic        out_take;

  always_comb begin
    sum_add = acc_r + {4'd0, in_adc_sample};
    sum_now = first_r ? {sum_add[11:0], 4'd0} : sum_add;
    cnt_inc = cnt_r + 5'd1;

    cur_c    = pass_r ? cb_r : ca_r;
    idx_prev = idx_r - 4'd1;
    lo = curve_point(cur_c, 4'd0);
    hi = curve_point(cur_c, 4'(POINTS - 1));
    ti = curve_point(cur_c, idx_r);
    tp = curve_point(cur_c, idx_prev);
    lo_sum = {1'b0, v_r} + {8'd0, LOW_MARGIN[cur_c]};
    hi_sum = {1'b0, hi} + {8'd0, HIGH_MARGIN[cur_c]};
    m_open  = lo_sum < {1'b0, lo};
    m_low   = v_r <= lo;
    m_short = {1'b0, v_r} > hi_sum;
    m_high  = v_r >= hi;
    if (m_open)       margin_val = HUM_OPEN;
    else if (m_low)   margin_val = HUM_LOW;
    else if (m_short) margin_val = HUM_SHORT;
    else              margin_val = HUM_HIGH;
    d_now    = ti - tp;
    num_init = 19'(19'(v_r - tp) * 19'd5) + {4'd0, d_now[15:1]};

    // Curve choice: temperatures 5..44 split into five-degree bands.
    tm_full   = in_air_temperature - 8'sd5;
    tm        = tm_full[5:0];
    tm_scaled = 13'({7'd0, tm} * 13'd205);
    c_sel     = tm_scaled[13-1:10] > 3'd7 ? 4'd7 : {1'b0, tm_scaled[12:10]};

    diff     = $signed({1'b0, h1_r}) - $signed({1'b0, hcur_r});
    prod     = $signed({8'd0, frac_r}) * 11'(diff);
    prod_abs = prod[10] ? 10'(-prod) : prod[9:0];
    q_scaled = {10'd0, prod_abs} * 20'd205;
    q5       = q_scaled[16:10];
    blend    = prod[10] ? h1_r + q5 : h1_r - q5;

    out_take = out_valid_r && !out_stall;

    status.result_item = first_r || cnt_inc[4];
    status.limit_hit   = (v_r > close_r) || (v_r < open_r);
    status.margin_hit  = m_open || m_low || m_short || m_high;
    status.found       = v_r <= ti;
    status.div_done    = (d_r == 16'd0) || (num_r < {3'd0, d_r});
    status.pass_b      = pass_r;
    status.out_free    = !out_valid_r || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      cnt_r       <= '0;
      first_r     <= 1'b1;
      open_r      <= OPEN_LIMIT_RST;
      close_r     <= CLOSE_LIMIT_RST;
      out_valid_r <= 1'b0;
      pass_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_OPEN:  open_r  <= cfg_data;
          REG_CLOSE: close_r <= cfg_data;
          default: ;
        endcase
      end
      // A new result loads the output register; otherwise an accepted one empties it.
      if ((cmd.op == ST_DONE) && status.out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        ST_IDLE: begin
          if (cmd.accept) begin
            if (first_r || cnt_inc[4]) begin
              acc_r   <= '0;
              cnt_r   <= '0;
              first_r <= 1'b0;
              v_r     <= sum_now;
              pass_r  <= 1'b0;
              if (in_air_temperature < 8'sd5) begin
                ca_r <= 4'd0; cb_r <= 4'd0; frac_r <= 3'd0;
              end else if (in_air_temperature >= 8'sd45) begin
                ca_r <= 4'(CURVES - 1); cb_r <= 4'(CURVES - 1); frac_r <= 3'd0;
              end else begin
                ca_r   <= c_sel;
                cb_r   <= c_sel + 4'd1;
                frac_r <= 3'(tm - 6'({2'd0, c_sel} * 6'd5));
              end
            end else begin
              acc_r <= sum_now;
              cnt_r <= cnt_inc;
            end
          end
        end
        ST_LIMIT: begin
          // A shorted sensor wins over an open one.
          hres_r <= (v_r > close_r) ? HUM_SHORT : HUM_OPEN;
        end
        ST_MARGIN: begin
          hcur_r <= margin_val;
          idx_r  <= 4'd1;
        end
        ST_SEARCH: begin
          if (v_r <= ti) begin
            d_r    <= d_now;
            num_r  <= num_init;
            q_r    <= 3'd0;
            base_r <= 7'(idx_r * 7'd5) + HUM_OFFSET;
          end else begin
            idx_r <= idx_r + 4'd1;
          end
        end
        ST_DIV: begin
          if ((d_r == 16'd0) || (num_r < {3'd0, d_r})) begin
            hcur_r <= base_r + {4'd0, q_r};
          end else begin
            num_r <= num_r - {3'd0, d_r};
            q_r   <= q_r + 3'd1;
          end
        end
        ST_STORE: begin
          if (!pass_r) begin
            h1_r   <= hcur_r;
            pass_r <= 1'b1;
          end
        end
        ST_BLEND: hres_r <= blend;
        ST_DONE: begin
          if (!out_valid_r || !out_stall) begin
            hum_r     <= hres_r;
            sum_out_r <= v_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid            = out_valid_r;
  assign out_humidity_percent = hum_r;
  assign out_sample_sum       = sum_out_r;

endmodule

// ===== hdl/humidity_table_linearizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// humidity_table_linearizer: humidity sensor linearizer
// Sums converter samples and maps each sum to relative humidity.
// ----------------------------------------------------------------------------
// Every accepted transaction adds one 12-bit sample to a 16-bit sum; after
// sixteen samples (or right after the very first sample following reset,
// which counts sixteen times) the sum is turned into a humidity percentage
// and one result transaction is issued, and the sum starts over from zero.
// A sum is linearized one item at a time by a sequencer: a limit check,
// then each of the two neighboring curves is evaluated by a serial search
// through the 15 ROM points (one point a cycle) and a repeated-subtraction
// divide, both skipped when the sum lies outside that curve's margins, and a
// final blend state mixes the two curves by temperature; a tripped limit
// skips curves and blend. The input stalls while a sum is linearized.
// Results sit in an output register, so new samples are taken while a
// finished result waits on a stalled output.
// Register 0 is the open-sensor limit, register 1 the shorted-sensor limit;
// write them only while the block is idle.
// ----------------------------------------------------------------------------
module humidity_table_linearizer import htl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] in_adc_sample,
  input  logic signed [7:0] in_air_temperature,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  out_humidity_percent,
  output logic [15:0] out_sample_sum,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  // The controller only sequences; all arithmetic lives in the datapath.
  htl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  htl_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .status               (status),
    .in_adc_sample        (in_adc_sample),
    .in_air_temperature   (in_air_temperature),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_humidity_percent (out_humidity_percent),
    .out_sample_sum       (out_sample_sum)
  );

endmodule

// ===== hdl/htl_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htl_checker: port-level checks
// Watches the result channel of the linearizer.
// ----------------------------------------------------------------------------
module htl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [6:0]  out_humidity_percent,
  input logic [15:0] out_sample_sum
);

  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_humidity_percent >= 7'd19 && out_humidity_percent <= 7'd91))
    else $error("humidity out of range");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_humidity_percent)
      && $stable(out_sample_sum))
    else $error("stalled result changed");

endmodule

bind humidity_table_linearizer htl_checker u_htl_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_humidity_percent (out_humidity_percent),
  .out_sample_sum       (out_sample_sum)
);
